/* src/deterministic_frame_generator_macros.svh */
// Assertion macros shared by the frame generator RTL.
`ifndef DETERMINISTIC_FRAME_GENERATOR_MACROS_SVH
`define DETERMINISTIC_FRAME_GENERATOR_MACROS_SVH

// same-cycle implication
`define DFG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DFG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/dfg_pkg.sv */
// Shared types and constants of the deterministic frame generator.
package dfg_pkg;

	localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_C1 = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_C2 = 64'h94D049BB133111EB;

	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_SEED  = 2'd1;
	localparam logic [1:0] REG_LEN   = 2'd2;
	localparam logic [1:0] REG_HOSTS = 2'd3;

	localparam logic [2:0] MODE_KNOWN   = 3'd0;
	localparam logic [2:0] MODE_BCAST   = 3'd1;
	localparam logic [2:0] MODE_UNKNOWN = 3'd2;
	localparam logic [2:0] MODE_MIXED   = 3'd3;
	localparam logic [2:0] MODE_FLOOD   = 3'd4;
	localparam logic [2:0] MODE_SCAN    = 3'd5;
	localparam logic [2:0] MODE_STORM   = 3'd6;
	localparam logic [2:0] MODE_UNUSED  = 3'd7;

	localparam int ETH_HDR = 14;
	localparam int IP_HDR  = 20;
	localparam int UDP_HDR = 8;

	// load enables of the four mixer stages
	typedef struct packed {
		logic ld1;
		logic ld2;
		logic ld3;
		logic ld4;
	} mix_ctl_t;

endpackage

/* src/dfg_mix64.sv */
// Four-stage pipelined splitmix64 finalizer built from 32x32 partial products.
module dfg_mix64 (
	input  logic              clk,
	input  dfg_pkg::mix_ctl_t ctl,
	input  logic [63:0]       z,
	output logic [63:0]       h
);

	logic [63:0] a;
	logic [63:0] b;
	logic [63:0] c;
	logic [63:0] d;
	logic [63:0] pa_s1;
	logic [31:0] pb_s1;
	logic [31:0] pc_s1;
	logic [63:0] c_s2;
	logic [63:0] pa_s3;
	logic [31:0] pb_s3;
	logic [31:0] pc_s3;
	logic [63:0] h_s4;

	assign a = z ^ (z >> 30);
	assign b = pa_s1 + {pb_s1 + pc_s1, 32'd0};
	assign c = b ^ (b >> 27);
	assign d = pa_s3 + {pb_s3 + pc_s3, 32'd0};

	always_ff @(posedge clk) begin
		if (ctl.ld1) begin
			pa_s1 <= 64'(a[31:0]) * 64'(dfg_pkg::MIX_C1[31:0]);
			pb_s1 <= a[31:0] * dfg_pkg::MIX_C1[63:32];
			pc_s1 <= a[63:32] * dfg_pkg::MIX_C1[31:0];
		end
		if (ctl.ld2) begin
			c_s2 <= c;
		end
		if (ctl.ld3) begin
			pa_s3 <= 64'(c_s2[31:0]) * 64'(dfg_pkg::MIX_C2[31:0]);
			pb_s3 <= c_s2[31:0] * dfg_pkg::MIX_C2[63:32];
			pc_s3 <= c_s2[63:32] * dfg_pkg::MIX_C2[31:0];
		end
		if (ctl.ld4) begin
			h_s4 <= d ^ (d >> 31);
		end
	end

	assign h = h_s4;

endmodule

/* src/deterministic_frame_generator.sv */
// Top level of the deterministic Ethernet/IPv4/UDP frame byte generator.
//
// Input stream s_*: one request per transfer, s_tdata = sequence_req[63:0],
// byte_offset[74:64]. Output stream m_*: one result per request, in order,
// m_tdata = frame_byte, m_tlast = last_byte, m_tuser = in_frame.
// Configuration channel cfg_*: cfg_addr selects traffic_mode (0), random_seed
// (1), frame_length (2) or the number of hosts (3); cfg_ready is always high.
// Write it only while no request is in flight.
// Pipeline of eleven stages: one request is taken every cycle while the output
// is not stalled by the receiver. The length is set by the
// 64-bit modulo by the host count (eight bits per stage) running beside the
// seed multiply and two four-stage splitmix64 mixers.
// Each stage has its own valid bit and loads when it is empty or the next
// stage loads, so a stalled receiver holds the output register and bubbles
// still close up behind it; nothing is lost or repeated.
// Reset empties the pipeline and restores the register defaults.
`include "deterministic_frame_generator_macros.svh"

module deterministic_frame_generator #(
	parameter int MAX_FRAME_BYTES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // [63:0] sequence_req, [74:64] byte_offset
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] frame_byte
	output logic        m_tlast,
	output logic [0:0]  m_tuser,   // [0] in_frame
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_addr,
	input  logic [63:0] cfg_data
);

	localparam int LW = $clog2(MAX_FRAME_BYTES + 1);
	localparam int NS = 11;

	typedef struct packed {
		logic [10:0] off;
		logic [15:0] seq16;
		logic [15:0] src;
		logic [15:0] dst;
		logic [15:0] sport;
		logic [15:0] dport;
		logic        udp;
		logic        bcast;
		logic        unk;
		logic [31:0] ent;
		logic [63:0] z;
	} dec_t;

	function automatic logic [15:0] div_chunk(logic [15:0] r, logic [7:0] bits,
	                                          logic [15:0] dv);
		logic [16:0] t;
		logic [15:0] rr;
		rr = r;
		for (int i = 7; i >= 0; i--) begin
			t = {rr, bits[i]};
			if (t >= {1'b0, dv})
				t = t - {1'b0, dv};
			rr = t[15:0];
		end
		return rr;
	endfunction

	function automatic logic [1:0] mod3(logic [6:0] v);
		logic [3:0] a;
		logic [2:0] b;
		a = 4'(v[6]) + 4'(v[5:4]) + 4'(v[3:2]) + 4'(v[1:0]);
		b = 3'(a[3:2]) + 3'(a[1:0]);
		if (b >= 3'd3)
			b = b - 3'd3;
		return b[1:0];
	endfunction

	function automatic logic [7:0] mac_byte(logic host_kind, logic bc, logic [15:0] host,
	                                        logic [31:0] ent, logic [2:0] i);
		logic [7:0] b;
		if (bc)
			b = 8'hff;
		else if (i == 3'd0)
			b = 8'h02;
		else if (host_kind) begin
			case (i)
				3'd1: b = 8'h57;
				3'd2: b = 8'h4c;
				3'd3: b = 8'h00;
				3'd4: b = host[15:8];
				default: b = host[7:0];
			endcase
		end else begin
			case (i)
				3'd1: b = 8'hfe;
				3'd2: b = ent[31:24];
				3'd3: b = ent[23:16];
				3'd4: b = ent[15:8];
				default: b = ent[7:0];
			endcase
		end
		return b;
	endfunction

	// configuration
	logic [2:0]  tm_q;
	logic [63:0] seed_q;
	logic [11:0] flen_q;
	logic [15:0] hc_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tm_q   <= dfg_pkg::MODE_KNOWN;
			seed_q <= 64'd0;
			flen_q <= 12'd64;
			hc_q   <= 16'd2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				dfg_pkg::REG_MODE:  tm_q   <= cfg_data[2:0];
				dfg_pkg::REG_SEED:  seed_q <= cfg_data;
				dfg_pkg::REG_LEN:   flen_q <= cfg_data[11:0];
				dfg_pkg::REG_HOSTS: hc_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// frame geometry from configuration
	logic [LW-1:0] len;
	logic [LW-1:0] plen;
	logic [15:0]   plen16;
	logic          frame_ok;

	assign len      = (32'(flen_q) > MAX_FRAME_BYTES) ? LW'(MAX_FRAME_BYTES) : LW'(flen_q);
	assign plen     = len - LW'(dfg_pkg::ETH_HDR);
	assign plen16   = 16'(plen);
	assign frame_ok = (32'(len) >= dfg_pkg::ETH_HDR) && (hc_q >= 16'd2);

	// stage handshake
	logic [NS:1] vld_s;
	logic [NS:1] rdy;

	always_comb begin
		rdy[NS] = !vld_s[NS] || m_tready;
		for (int k = NS - 1; k >= 1; k--)
			rdy[k] = !vld_s[k] || rdy[k+1];
	end

	assign s_tready = rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[1])
				vld_s[1] <= s_tvalid;
			for (int k = 2; k <= NS; k++)
				if (rdy[k])
					vld_s[k] <= vld_s[k-1];
		end
	end

	// stages 1..8: sequence, offset and the running remainder seq % hosts
	logic [63:0] seq_s [1:8];
	logic [10:0] off_s [1:8];
	logic [15:0] rem_s [1:8];
	logic [1:0]  m3_s  [3:8];

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			seq_s[1] <= s_tdata[63:0];
			off_s[1] <= s_tdata[74:64];
			rem_s[1] <= div_chunk(16'd0, s_tdata[63:56], hc_q);
		end
		for (int k = 2; k <= 8; k++) begin
			if (rdy[k]) begin
				seq_s[k] <= seq_s[k-1];
				off_s[k] <= off_s[k-1];
				rem_s[k] <= div_chunk(rem_s[k-1], seq_s[k-1][71-8*k -: 8], hc_q);
			end
		end
	end

	// stage 2: partial products of seq*G and (k+2)*G, base-4 digit sums
	logic [10:0] p1;
	logic [8:0]  k2;
	logic [63:0] gp0_s2;
	logic [31:0] gp1_s2;
	logic [31:0] gp2_s2;
	logic [63:0] kp0_s2;
	logic [31:0] kp1_s2;
	logic [3:0]  ds_s2 [0:7];

	assign p1 = off_s[1] - 11'(dfg_pkg::ETH_HDR);
	assign k2 = 9'(p1[10:3]) + 9'd2;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			gp0_s2 <= 64'(seq_s[1][31:0]) * 64'(dfg_pkg::GOLDEN[31:0]);
			gp1_s2 <= seq_s[1][31:0] * dfg_pkg::GOLDEN[63:32];
			gp2_s2 <= seq_s[1][63:32] * dfg_pkg::GOLDEN[31:0];
			kp0_s2 <= 64'(k2) * 64'(dfg_pkg::GOLDEN[31:0]);
			kp1_s2 <= 32'(k2) * dfg_pkg::GOLDEN[63:32];
			for (int j = 0; j < 8; j++)
				ds_s2[j] <= 4'(seq_s[1][8*j +: 2]) + 4'(seq_s[1][8*j+2 +: 2])
				          + 4'(seq_s[1][8*j+4 +: 2]) + 4'(seq_s[1][8*j+6 +: 2]);
		end
	end

	// stage 3: base state, draw offset, seq % 3
	logic [63:0] base_s3;
	logic [63:0] kg_s3;
	logic [6:0]  dtot;

	always_comb begin
		dtot = 7'd0;
		for (int j = 0; j < 8; j++)
			dtot = dtot + 7'(ds_s2[j]);
	end

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			base_s3  <= seed_q ^ (gp0_s2 + {gp1_s2 + gp2_s2, 32'd0});
			kg_s3    <= kp0_s2 + {kp1_s2, 32'd0};
			m3_s[3]  <= mod3(dtot);
		end
		for (int k = 4; k <= 8; k++)
			if (rdy[k])
				m3_s[k] <= m3_s[k-1];
	end

	// stage 4: mixer inputs
	logic [63:0] x_s4;
	logic [63:0] y_s4;

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			x_s4 <= base_s3 + dfg_pkg::GOLDEN;
			y_s4 <= base_s3 + kg_s3;
		end
	end

	// stages 5..8: mixers
	dfg_pkg::mix_ctl_t mix_ctl;
	logic [63:0]       ent_h;
	logic [63:0]       pay_h;

	assign mix_ctl.ld1 = rdy[5];
	assign mix_ctl.ld2 = rdy[6];
	assign mix_ctl.ld3 = rdy[7];
	assign mix_ctl.ld4 = rdy[8];

	dfg_mix64 u_mix_ent (
		.clk (clk),
		.ctl (mix_ctl),
		.z   (x_s4),
		.h   (ent_h)
	);

	dfg_mix64 u_mix_pay (
		.clk (clk),
		.ctl (mix_ctl),
		.z   (y_s4),
		.h   (pay_h)
	);

	// stage 9: scenario decode
	logic [2:0]  mode;
	logic [16:0] nxt;
	dec_t        dec;
	dec_t        dec_s9;

	always_comb begin
		mode = tm_q;
		if (mode == dfg_pkg::MODE_UNUSED)
			mode = dfg_pkg::MODE_KNOWN;
		if (mode == dfg_pkg::MODE_MIXED)
			mode = {1'b0, m3_s[8]};
		nxt = 17'(rem_s[8]) + 17'd1;
		dec       = '0;
		dec.off   = off_s[8];
		dec.seq16 = seq_s[8][15:0];
		dec.ent   = ent_h[31:0];
		dec.z     = pay_h;
		case (mode)
			dfg_pkg::MODE_FLOOD: begin
				dec.dst   = 16'd1;
				dec.udp   = 1'b1;
				dec.sport = {2'b11, ent_h[13:0]};
				dec.dport = 16'd9000;
			end
			dfg_pkg::MODE_SCAN: begin
				dec.dst   = 16'd1;
				dec.udp   = 1'b1;
				dec.sport = 16'd44444;
				dec.dport = 16'(seq_s[8][9:0]) + 16'd1;
			end
			dfg_pkg::MODE_STORM: begin
				dec.src   = (hc_q == 16'd2) ? 16'(seq_s[8][0]) : 16'(m3_s[8]);
				dec.dst   = 16'hffff;
				dec.udp   = 1'b1;
				dec.bcast = 1'b1;
				dec.sport = 16'd137;
				dec.dport = 16'd137;
			end
			default: begin
				dec.src   = rem_s[8];
				dec.dst   = (nxt == 17'(hc_q)) ? 16'd0 : nxt[15:0];
				dec.bcast = (mode == dfg_pkg::MODE_BCAST);
				dec.unk   = (mode == dfg_pkg::MODE_UNKNOWN);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy[9])
			dec_s9 <= dec;
	end

	// stage 10: UDP fit and IPv4 header sum
	logic        udp_fit;
	logic [7:0]  proto;
	dec_t        dec_u;
	dec_t        dec_s10;
	logic [19:0] sum_s10;

	assign udp_fit = dec_s9.udp && (32'(plen) >= dfg_pkg::IP_HDR + dfg_pkg::UDP_HDR);
	assign proto   = udp_fit ? 8'd17 : 8'd0;

	always_comb begin
		dec_u     = dec_s9;
		dec_u.udp = udp_fit;
	end

	always_ff @(posedge clk) begin
		if (rdy[10]) begin
			dec_s10     <= dec_u;
			sum_s10     <= 20'(16'h4500) + 20'(plen16) + 20'(dec_s9.seq16)
			             + 20'({8'd64, proto}) + 20'(16'h0a00) + 20'(dec_s9.src)
			             + 20'(16'h0a00) + 20'(dec_s9.dst);
		end
	end

	// stage 11: byte select into the output register
	logic [16:0] fold1;
	logic [16:0] fold2;
	logic [15:0] ck;
	logic [10:0] p;
	logic [2:0]  q;
	logic [15:0] w;
	logic        inf;
	logic        lst;
	logic [7:0]  b;
	logic [7:0]  byte_s11;
	logic        last_s11;
	logic        inf_s11;

	always_comb begin
		fold1 = 17'(sum_s10[15:0]) + 17'(sum_s10[19:16]);
		fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
		ck    = ~fold2[15:0];
		p     = dec_s10.off - 11'(dfg_pkg::ETH_HDR);
		q     = 3'(p - 11'(dfg_pkg::IP_HDR));
		case (q[2:1])
			2'd0: w = dec_s10.sport;
			2'd1: w = dec_s10.dport;
			2'd2: w = plen16 - 16'(dfg_pkg::IP_HDR);
			default: w = 16'd0;
		endcase
		inf = frame_ok && (32'(dec_s10.off) < 32'(len));
		lst = inf && (32'(dec_s10.off) == 32'(len) - 1);
		if (dec_s10.off < 11'd6)
			b = mac_byte(!dec_s10.unk, dec_s10.bcast, dec_s10.dst, dec_s10.ent,
			             dec_s10.off[2:0]);
		else if (dec_s10.off < 11'd12)
			b = mac_byte(1'b1, 1'b0, dec_s10.src, dec_s10.ent, 3'(dec_s10.off - 11'd6));
		else if (dec_s10.off == 11'd12)
			b = 8'h08;
		else if (dec_s10.off == 11'd13)
			b = 8'h00;
		else if ((32'(plen) >= dfg_pkg::IP_HDR) && (32'(p) < dfg_pkg::IP_HDR)) begin
			case (p[4:0])
				5'd0:  b = 8'h45;
				5'd2:  b = plen16[15:8];
				5'd3:  b = plen16[7:0];
				5'd4:  b = dec_s10.seq16[15:8];
				5'd5:  b = dec_s10.seq16[7:0];
				5'd8:  b = 8'd64;
				5'd9:  b = dec_s10.udp ? 8'd17 : 8'd0;
				5'd10: b = ck[15:8];
				5'd11: b = ck[7:0];
				5'd12: b = 8'd10;
				5'd14: b = dec_s10.src[15:8];
				5'd15: b = dec_s10.src[7:0];
				5'd16: b = 8'd10;
				5'd18: b = dec_s10.dst[15:8];
				5'd19: b = dec_s10.dst[7:0];
				default: b = 8'h00;
			endcase
		end else if (dec_s10.udp && (32'(p) < dfg_pkg::IP_HDR + dfg_pkg::UDP_HDR))
			b = q[0] ? w[7:0] : w[15:8];
		else
			b = 8'(dec_s10.z >> {p[2:0], 3'b000});
		if (!inf)
			b = 8'h00;
	end

	always_ff @(posedge clk) begin
		if (rdy[11]) begin
			byte_s11 <= b;
			last_s11 <= lst;
			inf_s11  <= inf;
		end
	end

	assign m_tvalid = vld_s[NS];
	assign m_tdata  = byte_s11;
	assign m_tlast  = last_s11;
	assign m_tuser  = inf_s11;

	`DFG_ASSERT_NOW(a_out_zero, m_tvalid && !m_tuser[0], m_tdata == 8'h00 && !m_tlast, "byte outside frame not zero")
	`DFG_ASSERT_NOW(a_last_in, m_tvalid && m_tlast, m_tuser[0], "last byte outside frame")
	`DFG_ASSERT_NOW(a_ready_empty, !vld_s[1], s_tready, "input blocked with empty first stage")
	`DFG_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid, "stalled result dropped")

endmodule

/* tb/testbench.sv */
// Self-checking testbench of the deterministic frame byte generator.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_BYTES = 2048;
	localparam int PIPE_LAT = 12;
	localparam int WATCHDOG = 20000;
	localparam int N_RANDOM = 1550;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
		logic       in_frame;
	} byte_res_t;

	typedef struct {
		logic [63:0] seq;
		logic [10:0] off;
		logic        typed;
		byte_res_t   res;
	} req_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [0:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_addr = '0;
	logic [63:0] cfg_data = '0;

	logic [2:0]  cur_mode;
	logic [63:0] cur_seed;
	logic [11:0] cur_len;
	logic [15:0] cur_hosts;

	logic [2:0]  mode_set[8] = '{dfg_pkg::MODE_KNOWN, dfg_pkg::MODE_BCAST,
		dfg_pkg::MODE_UNKNOWN, dfg_pkg::MODE_MIXED, dfg_pkg::MODE_FLOOD,
		dfg_pkg::MODE_SCAN, dfg_pkg::MODE_STORM, dfg_pkg::MODE_UNUSED};
	logic [11:0] len_set[7] = '{12'd14, 12'd33, 12'd42, 12'd64, 12'd100, 12'd2048, 12'hfff};

	byte_res_t pending_bytes[$];
	int        n_errors = 0;
	int        n_checked = 0;
	int        n_in_frame = 0;
	int        idle_cycles = 0;
	bit        hold_rx = 1'b0;

	deterministic_frame_generator #(.MAX_FRAME_BYTES(MAX_BYTES)) dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [63:0] mix64(input logic [63:0] z);
		z = (z ^ (z >> 30)) * dfg_pkg::MIX_C1;
		z = (z ^ (z >> 27)) * dfg_pkg::MIX_C2;
		return z ^ (z >> 31);
	endfunction

	function automatic logic [7:0] mac_octet(input bit is_host, input bit bcast,
			input logic [31:0] host, input logic [63:0] ent, input int i);
		if (bcast) return 8'hff;
		if (i == 0) return 8'h02;
		if (is_host) begin
			if (i == 1) return 8'h57;
			if (i == 2) return 8'h4c;
			return 8'(host >> (8 * (5 - i)));
		end
		if (i == 1) return 8'hfe;
		return 8'(ent >> (8 * (5 - i)));
	endfunction

	function automatic byte_res_t frame_byte_at(input logic [63:0] seq, input logic [10:0] off);
		byte_res_t r;
		logic [63:0] len, hc, base, ent, z;
		logic [2:0] mode;
		logic [31:0] src, dst, plen, p, sum;
		logic [15:0] sport, dport, ck, w;
		logic [7:0] hdr[20];
		bit udp, dbcast, dunk;
		r = '0;
		src = 0; dst = 0; sport = 0; dport = 0;
		udp = 0; dbcast = 0; dunk = 0;
		len = (cur_len > MAX_BYTES) ? 64'(MAX_BYTES) : 64'(cur_len);
		hc = 64'(cur_hosts);
		if (len < dfg_pkg::ETH_HDR || hc < 2 || 64'(off) >= len) return r;
		base = cur_seed ^ (seq * dfg_pkg::GOLDEN);
		ent = mix64(base + dfg_pkg::GOLDEN);
		mode = cur_mode;
		if (mode == dfg_pkg::MODE_UNUSED) mode = dfg_pkg::MODE_KNOWN;
		if (mode == dfg_pkg::MODE_MIXED) mode = 3'(seq % 3);
		case (mode)
			dfg_pkg::MODE_FLOOD: begin
				dst = 1; udp = 1;
				sport = 16'hC000 | 16'(ent & 64'h3FFF);
				dport = 9000;
			end
			dfg_pkg::MODE_SCAN: begin
				dst = 1; udp = 1;
				sport = 44444;
				dport = 16'(1 + seq % 1024);
			end
			dfg_pkg::MODE_STORM: begin
				src = 32'(seq % (hc < 3 ? hc : 3));
				dst = 32'hffff; udp = 1; dbcast = 1;
				sport = 137; dport = 137;
			end
			default: begin
				src = 32'(seq % hc);
				dst = 32'((64'(src) + 1) % hc);
				dbcast = (mode == dfg_pkg::MODE_BCAST);
				dunk = (mode == dfg_pkg::MODE_UNKNOWN);
			end
		endcase
		plen = 32'(len) - dfg_pkg::ETH_HDR;
		if (udp && plen < dfg_pkg::IP_HDR + dfg_pkg::UDP_HDR) udp = 0;
		if (off < 6) r.frame_byte = mac_octet(!dunk, dbcast, dst, ent, off);
		else if (off < 12) r.frame_byte = mac_octet(1, 0, src, ent, off - 6);
		else if (off == 12) r.frame_byte = 8'h08;
		else if (off == 13) r.frame_byte = 8'h00;
		else begin
			p = off - dfg_pkg::ETH_HDR;
			if (plen >= dfg_pkg::IP_HDR && p < dfg_pkg::IP_HDR) begin
				hdr = '{8'h45, 8'd0, plen[15:8], plen[7:0], seq[15:8], seq[7:0], 8'd0, 8'd0,
					8'd64, udp ? 8'd17 : 8'd0, 8'd0, 8'd0, 8'd10, 8'd0, src[15:8], src[7:0],
					8'd10, 8'd0, dst[15:8], dst[7:0]};
				sum = 0;
				for (int i = 0; i < dfg_pkg::IP_HDR; i += 2) sum += {hdr[i], hdr[i + 1]};
				while (sum >> 16) sum = (sum & 32'hffff) + (sum >> 16);
				ck = ~sum[15:0];
				hdr[10] = ck[15:8]; hdr[11] = ck[7:0];
				r.frame_byte = hdr[p];
			end else if (udp && p < dfg_pkg::IP_HDR + dfg_pkg::UDP_HDR) begin
				case ((p - dfg_pkg::IP_HDR) >> 1)
					0: w = sport;
					1: w = dport;
					2: w = 16'(plen - dfg_pkg::IP_HDR);
					default: w = 0;
				endcase
				r.frame_byte = p[0] ? w[7:0] : w[15:8];
			end else begin
				z = mix64(base + (64'(p >> 3) + 2) * dfg_pkg::GOLDEN);
				r.frame_byte = 8'(z >> (8 * p[2:0]));
			end
		end
		r.last_byte = (64'(off) == len - 1);
		r.in_frame = 1'b1;
		return r;
	endfunction

	task automatic report(input string what, input byte_res_t got, input byte_res_t want);
		n_errors++;
		$display("mismatch %s at %0t: got byte %02h last %0d in %0d, want %02h %0d %0d",
			what, $time, got.frame_byte, got.last_byte, got.in_frame,
			want.frame_byte, want.last_byte, want.in_frame);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			dfg_pkg::REG_MODE:  cur_mode = val[2:0];
			dfg_pkg::REG_SEED:  cur_seed = val;
			dfg_pkg::REG_LEN:   cur_len = val[11:0];
			dfg_pkg::REG_HOSTS: cur_hosts = val[15:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// valid stays up after a transfer until the next call or drain decides
	task automatic send_req(input logic [63:0] seq, input logic [10:0] off,
			input bit typed, input byte_res_t want);
		byte_res_t model;
		int        gap;
		gap = $urandom_range(0, 4);
		model = frame_byte_at(seq, off);
		if (typed && model != want) report("table", model, want);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, off, seq};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_bytes.insert(pending_bytes.size(), model);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (PIPE_LAT) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver: after each transfer drops ready for a randomly drawn wait
	initial begin
		int wait_n;
		wait_n = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) wait_n = $urandom_range(0, 4);
			@(negedge clk);
			if (hold_rx) m_tready <= 1'b0;
			else if (wait_n != 0) begin
				m_tready <= 1'b0;
				wait_n--;
			end else m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		byte_res_t got, want;
		if (m_tvalid && m_tready) begin
			got = '{m_tdata, m_tlast, m_tuser[0]};
			if (pending_bytes.size() == 0) report("unexpected", got, '0);
			else begin
				want = pending_bytes.pop_front();
				if (got.frame_byte != want.frame_byte) report("frame_byte", got, want);
				if (got.last_byte != want.last_byte) report("last_byte", got, want);
				if (got.in_frame != want.in_frame) report("in_frame", got, want);
				n_checked++;
				if (got.in_frame) n_in_frame++;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_valid) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog expired, %0d results outstanding", pending_bytes.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		req_row_t dir_rows[$];
		logic [63:0] seq;
		logic [10:0] off;
		int          lim, n_sent;
		cur_mode = dfg_pkg::MODE_KNOWN; cur_seed = 0; cur_len = 64; cur_hosts = 2;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset defaults: known unicast, seq 0 -> dst host 1, src host 0
		dir_rows = '{
			'{64'd0, 11'd0, 1, '{8'h02, 1'b0, 1'b1}},
			'{64'd0, 11'd5, 1, '{8'h01, 1'b0, 1'b1}},
			'{64'd0, 11'd11, 1, '{8'h00, 1'b0, 1'b1}},
			'{64'd0, 11'd12, 1, '{8'h08, 1'b0, 1'b1}},
			'{64'd0, 11'd13, 1, '{8'h00, 1'b0, 1'b1}},
			'{64'd0, 11'd14, 1, '{8'h45, 1'b0, 1'b1}},
			'{64'd0, 11'd17, 1, '{8'd50, 1'b0, 1'b1}},
			'{64'd0, 11'd22, 1, '{8'd64, 1'b0, 1'b1}},
			'{64'd0, 11'd63, 0, '0},
			'{64'd0, 11'd64, 1, '0},
			'{64'd0, 11'd2047, 1, '0},
			'{64'hffff_ffff_ffff_ffff, 11'd18, 1, '{8'hff, 1'b0, 1'b1}},
			'{64'hffff_ffff_ffff_ffff, 11'd40, 0, '0},
			'{64'h8000_0000_0000_0001, 11'd30, 0, '0}
		};
		foreach (dir_rows[i]) send_req(dir_rows[i].seq, dir_rows[i].off,
			dir_rows[i].typed, dir_rows[i].res);
		drain();
		// short frame, too few hosts, oversize length, every mode
		write_reg(dfg_pkg::REG_LEN, 64'd13);
		send_req(64'd7, 11'd0, 1, '0);
		drain();
		write_reg(dfg_pkg::REG_LEN, 64'hffff_ffff_ffff_ffff);
		write_reg(dfg_pkg::REG_HOSTS, 64'd1);
		send_req(64'd7, 11'd3, 1, '0);
		drain();
		write_reg(dfg_pkg::REG_HOSTS, 64'd0);
		send_req(64'd7, 11'd3, 1, '0);
		drain();
		write_reg(dfg_pkg::REG_HOSTS, 64'd65535);
		write_reg(dfg_pkg::REG_SEED, 64'hffff_ffff_ffff_ffff);
		foreach (mode_set[m]) begin
			drain();
			write_reg(dfg_pkg::REG_MODE, 64'(mode_set[m]));
			send_req(64'd12345, 11'd2047, 0, '0);
			send_req(64'd12345, 11'd3, 0, '0);
		end
		drain();

		// random phases over modes, lengths and host counts
		n_sent = 0;
		for (int ph = 0; n_sent < N_RANDOM; ph++) begin
			drain();
			write_reg(dfg_pkg::REG_MODE, 64'(mode_set[ph % 8]));
			write_reg(dfg_pkg::REG_SEED, {$urandom, $urandom});
			write_reg(dfg_pkg::REG_LEN, (ph % 9 == 8) ? 64'($urandom_range(0, 4095))
				: 64'(len_set[$urandom_range(0, 6)]));
			case ($urandom_range(0, 3))
				0: write_reg(dfg_pkg::REG_HOSTS, 64'd2);
				1: write_reg(dfg_pkg::REG_HOSTS, 64'd3);
				2: write_reg(dfg_pkg::REG_HOSTS, 64'd65535);
				default: write_reg(dfg_pkg::REG_HOSTS, 64'($urandom_range(0, 65535)));
			endcase
			lim = (cur_len > MAX_BYTES) ? MAX_BYTES : ((cur_len == 0) ? 1 : int'(cur_len));
			if (ph == 3) begin
				fork
					begin
						hold_rx = 1'b1;
						repeat (60) @(posedge clk);
						hold_rx = 1'b0;
					end
				join_none
			end
			seq = {$urandom, $urandom};
			for (int i = 0; i < 100 && n_sent < N_RANDOM; i++) begin
				// mostly pick random offsets inside the frame, sometimes its last byte or anywhere
				case ($urandom_range(0, 9))
					0: off = 11'($urandom);
					1: off = 11'(lim - 1);
					default: off = 11'($urandom_range(0, lim - 1));
				endcase
				if ($urandom_range(0, 7) == 0) seq = {$urandom, $urandom};
				else if ($urandom_range(0, 3) == 0) seq = seq + 1;
				send_req(seq, off, 0, '0);
				n_sent++;
			end
		end
		drain();
		$display("checked %0d results, %0d inside a frame, over all eight modes", n_checked,
			n_in_frame);
		$display("lengths from none through oversize, host counts 0 to 65535, one long stall");
		if (n_errors == 0 && pending_bytes.size() == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+src
src/dfg_pkg.sv
src/dfg_mix64.sv
src/deterministic_frame_generator.sv
tb/testbench.sv
